// File: rtl/ycw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycw_pkg
// Shared constants and types of the colour wheel pixel generator.
// ----------------------------------------------------------------------------
package ycw_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LUMA         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHROMA_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELLIPSE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd5;

	// divider depths
	localparam int CDIV_STEPS = 15;
	localparam int NDIV_STEPS = 8;

	// widths of the datapath
	localparam int SQ_W   = 25;
	localparam int AREA_W = 2 * SQ_W - 1;
	localparam int CM_W   = 22;
	localparam int NUM_W  = 30;

	// colour coefficients in q.8
	localparam logic [17:0] COEF_RV = 18'd74445;
	localparam logic [17:0] COEF_GU = 18'd25754;
	localparam logic [17:0] COEF_GV = 18'd37888;
	localparam logic [17:0] COEF_BU = 18'd132403;

	// cycles from an accepted start to the done strobe
	localparam int LATENCY = 32;
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	typedef struct packed {
		logic [SQ_W-1:0]   w_sq;
		logic [SQ_W-1:0]   h_sq;
		logic [AREA_W-1:0] wh_sq;
	} geom_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] row;
	} side_t;

	typedef struct packed {
		logic [7:0] plain_r;
		logic [7:0] plain_g;
		logic [7:0] plain_b;
		logic [2:0] pos;
	} chan_t;

endpackage

// File: rtl/ycw_chroma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycw_chroma_div
// Pipelined restoring divider, one quotient bit per stage: unscaled chroma
// magnitude round(|s| * 16384 / (n-1)) with the sign carried alongside.
// ----------------------------------------------------------------------------
module ycw_chroma_div import ycw_pkg::*; (
	input  logic               clk,
	input  logic [COORD_W-1:0] mag,
	input  logic [COORD_W-1:0] den_m1,
	input  logic               neg,
	output logic [14:0]        quot,
	output logic               quot_neg
);

	logic [12:0]        rem_s  [CDIV_STEPS];
	logic [14:0]        q_s    [CDIV_STEPS];
	logic [COORD_W-1:0] dm1_s  [CDIV_STEPS];
	logic               neg_s  [CDIV_STEPS];

	logic [12:0]        rem_n  [CDIV_STEPS];
	logic [14:0]        q_n    [CDIV_STEPS];
	logic [COORD_W-1:0] dm1_n  [CDIV_STEPS];
	logic               neg_n  [CDIV_STEPS];

	always_comb begin
		logic [12:0]        r_in;
		logic [14:0]        q_in;
		logic [COORD_W-1:0] d_in;
		logic               n_in;
		logic [14:0]        lo;
		logic [13:0]        trial;
		logic [13:0]        dd;
		for (int k = 0; k < CDIV_STEPS; k++) begin
			if (k == 0) begin
				r_in = {1'b0, mag};
				q_in = '0;
				d_in = den_m1;
				n_in = neg;
			end else begin
				r_in = rem_s[(k == 0) ? 0 : k - 1];
				q_in = q_s[(k == 0) ? 0 : k - 1];
				d_in = dm1_s[(k == 0) ? 0 : k - 1];
				n_in = neg_s[(k == 0) ? 0 : k - 1];
			end
			// low numerator bits are n-1 itself (the rounding half)
			lo    = {3'b000, d_in};
			trial = {r_in, lo[CDIV_STEPS-1-k]};
			dd    = {1'b0, d_in, 1'b0};
			if (trial >= dd) begin
				rem_n[k] = 13'(trial - dd);
				q_n[k]   = {q_in[13:0], 1'b1};
			end else begin
				rem_n[k] = trial[12:0];
				q_n[k]   = {q_in[13:0], 1'b0};
			end
			dm1_n[k] = d_in;
			neg_n[k] = n_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CDIV_STEPS; k++) begin
			rem_s[k] <= rem_n[k];
			q_s[k]   <= q_n[k];
			dm1_s[k] <= dm1_n[k];
			neg_s[k] <= neg_n[k];
		end
	end

	assign quot     = q_s[CDIV_STEPS-1];
	assign quot_neg = neg_s[CDIV_STEPS-1];

endmodule

// File: rtl/ycw_norm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycw_norm_div
// Pipelined restoring divider for normalisation: floor(num / den) where the
// quotient is known to fit in eight bits.
// ----------------------------------------------------------------------------
module ycw_norm_div import ycw_pkg::*; (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [CM_W-1:0]  den,
	output logic [7:0]       quot
);

	logic [CM_W-1:0] rem_s [NDIV_STEPS];
	logic [7:0]      lo_s  [NDIV_STEPS];
	logic [CM_W-1:0] den_s [NDIV_STEPS];
	logic [7:0]      q_s   [NDIV_STEPS];

	logic [CM_W-1:0] rem_n [NDIV_STEPS];
	logic [7:0]      lo_n  [NDIV_STEPS];
	logic [CM_W-1:0] den_n [NDIV_STEPS];
	logic [7:0]      q_n   [NDIV_STEPS];

	always_comb begin
		logic [CM_W-1:0] r_in;
		logic [7:0]      l_in;
		logic [CM_W-1:0] d_in;
		logic [7:0]      q_in;
		logic [CM_W:0]   trial;
		for (int k = 0; k < NDIV_STEPS; k++) begin
			if (k == 0) begin
				r_in = num[NUM_W-1:8];
				l_in = num[7:0];
				d_in = den;
				q_in = '0;
			end else begin
				r_in = rem_s[(k == 0) ? 0 : k - 1];
				l_in = lo_s[(k == 0) ? 0 : k - 1];
				d_in = den_s[(k == 0) ? 0 : k - 1];
				q_in = q_s[(k == 0) ? 0 : k - 1];
			end
			trial = {r_in, l_in[NDIV_STEPS-1-k]};
			if (trial >= {1'b0, d_in}) begin
				rem_n[k] = CM_W'(trial - {1'b0, d_in});
				q_n[k]   = {q_in[6:0], 1'b1};
			end else begin
				rem_n[k] = trial[CM_W-1:0];
				q_n[k]   = {q_in[6:0], 1'b0};
			end
			lo_n[k]  = l_in;
			den_n[k] = d_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NDIV_STEPS; k++) begin
			rem_s[k] <= rem_n[k];
			lo_s[k]  <= lo_n[k];
			den_s[k] <= den_n[k];
			q_s[k]   <= q_n[k];
		end
	end

	assign quot = q_s[NDIV_STEPS-1];

endmodule

// File: rtl/ycw_ellipse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycw_ellipse
// Exact inscribed-ellipse test over three register stages:
// du^2 h^2 + dv^2 w^2 <= w^2 h^2.
// ----------------------------------------------------------------------------
module ycw_ellipse import ycw_pkg::*; (
	input  logic               clk,
	input  logic signed [13:0] du,
	input  logic signed [13:0] dv,
	input  geom_t              geom,
	output logic               in_ell
);

	logic signed [27:0] du_sq;
	logic signed [27:0] dv_sq;
	logic [SQ_W-1:0]    du2_s2;
	logic [SQ_W-1:0]    dv2_s2;
	logic [2*SQ_W-1:0]  a_prod;
	logic [2*SQ_W-1:0]  b_prod;
	logic [AREA_W-1:0]  a_s3;
	logic [AREA_W-1:0]  b_s3;

	assign du_sq  = du * du;
	assign dv_sq  = dv * dv;
	assign a_prod = du2_s2 * geom.h_sq;
	assign b_prod = dv2_s2 * geom.w_sq;

	always_ff @(posedge clk) begin
		du2_s2 <= du_sq[SQ_W-1:0];
		dv2_s2 <= dv_sq[SQ_W-1:0];
		a_s3   <= a_prod[AREA_W-1:0];
		b_s3   <= b_prod[AREA_W-1:0];
		in_ell <= ({1'b0, a_s3} + {1'b0, b_s3}) <= {1'b0, geom.wh_sq};
	end

endmodule

// File: rtl/yuv_color_wheel_pixel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_color_wheel_pixel_top
// Colour wheel pixel generator: pixel coordinate to rgba through yuv chroma.
// ----------------------------------------------------------------------------
// throughput: one pixel every cycle while busy is low; every stage,
// dividers included, is pipelined
// busy is high after a configuration write while the derived image
// geometry settles; no other cycle holds off start
// reset sets the configuration registers to defaults and empties the pipeline
// ----------------------------------------------------------------------------
module yuv_color_wheel_pixel_top import ycw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [COORD_W-1:0]   column,
	input  logic [COORD_W-1:0]   row_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 done,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic [7:0]           alpha,
	output logic                 inside_res,
	output logic [COORD_W-1:0]   out_row
);

	// configuration
	logic [7:0]       luma_q;
	logic [15:0]      scale_q;
	logic             norm_q;
	logic             mask_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] wc_q;
	logic [DIM_W-1:0] hc_q;
	geom_t            geom_q;
	logic [1:0]       settle_q;

	logic [DIM_W-1:0]   wc_n;
	logic [DIM_W-1:0]   hc_n;
	logic [2*DIM_W-1:0] w_sq_n;
	logic [2*DIM_W-1:0] h_sq_n;
	logic [2*SQ_W-1:0]  wh_n;

	always_comb begin
		if (width_q < DIM_W'(2))
			wc_n = DIM_W'(2);
		else if (width_q > DIM_W'(MAX_DIM))
			wc_n = DIM_W'(MAX_DIM);
		else
			wc_n = width_q;
		if (height_q < DIM_W'(2))
			hc_n = DIM_W'(2);
		else if (height_q > DIM_W'(MAX_DIM))
			hc_n = DIM_W'(MAX_DIM);
		else
			hc_n = height_q;
	end

	assign w_sq_n = wc_q * wc_q;
	assign h_sq_n = hc_q * hc_q;
	assign wh_n   = geom_q.w_sq * geom_q.h_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_q       <= 8'd128;
			scale_q      <= 16'd4096;
			norm_q       <= 1'b0;
			mask_q       <= 1'b0;
			width_q      <= DIM_W'(256);
			height_q     <= DIM_W'(256);
			wc_q         <= DIM_W'(256);
			hc_q         <= DIM_W'(256);
			geom_q.w_sq  <= SQ_W'(65536);
			geom_q.h_sq  <= SQ_W'(65536);
			geom_q.wh_sq <= AREA_W'(64'h1_0000_0000);
			settle_q     <= 2'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LUMA:         luma_q   <= cfg_data[7:0];
					REG_CHROMA_SCALE: scale_q  <= cfg_data[15:0];
					REG_NORMALIZE:    norm_q   <= cfg_data[0];
					REG_ELLIPSE:      mask_q   <= cfg_data[0];
					REG_WIDTH:        width_q  <= cfg_data[DIM_W-1:0];
					REG_HEIGHT:       height_q <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			wc_q         <= wc_n;
			hc_q         <= hc_n;
			geom_q.w_sq  <= w_sq_n[SQ_W-1:0];
			geom_q.h_sq  <= h_sq_n[SQ_W-1:0];
			geom_q.wh_sq <= wh_n[AREA_W-1:0];
			if (cfg_we)
				settle_q <= SETTLE_CYCLES;
			else if (settle_q != 2'd0)
				settle_q <= settle_q - 2'd1;
		end
	end

	assign busy = (settle_q != 2'd0);

	// stage 1: clamp coordinates, chroma numerators, ellipse offsets
	logic [COORD_W-1:0] wm1;
	logic [COORD_W-1:0] hm1;
	logic [COORD_W-1:0] u_cl;
	logic [COORD_W-1:0] v_cl;
	logic signed [13:0] su;
	logic signed [13:0] sv;
	logic [13:0]        su_abs;
	logic [13:0]        sv_abs;
	logic               accept;

	assign wm1    = COORD_W'(wc_q - DIM_W'(1));
	assign hm1    = COORD_W'(hc_q - DIM_W'(1));
	assign u_cl   = (column > wm1) ? wm1 : column;
	assign v_cl   = (row_index > hm1) ? hm1 : row_index;
	assign su     = $signed({1'b0, u_cl, 1'b0}) - $signed({2'b00, wm1});
	assign sv     = $signed({1'b0, v_cl, 1'b0}) - $signed({2'b00, hm1});
	assign su_abs = su[13] ? 14'(-su) : su;
	assign sv_abs = sv[13] ? 14'(-sv) : sv;
	assign accept = start && !busy;

	logic [COORD_W-1:0] umag_s1;
	logic [COORD_W-1:0] vmag_s1;
	logic               uneg_s1;
	logic               vneg_s1;
	logic signed [13:0] du_s1;
	logic signed [13:0] dv_s1;

	always_ff @(posedge clk) begin
		umag_s1 <= su_abs[COORD_W-1:0];
		vmag_s1 <= sv_abs[COORD_W-1:0];
		uneg_s1 <= su[13];
		vneg_s1 <= sv[13];
		du_s1   <= $signed({1'b0, u_cl, 1'b0}) - $signed({1'b0, wc_q});
		dv_s1   <= $signed({1'b0, v_cl, 1'b0}) - $signed({1'b0, hc_q});
	end

	// side band: valid beat and output row
	side_t side_s [1:LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k < LATENCY; k++)
				side_s[k] <= '0;
		end else begin
			side_s[1].valid <= accept;
			side_s[1].row   <= hm1 - v_cl;
			for (int k = 2; k < LATENCY; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	// ellipse test, result lands with stage 4
	logic inside_s4;
	logic ins_s [5:LATENCY-1];

	ycw_ellipse u_ellipse (
		.clk    (clk),
		.du     (du_s1),
		.dv     (dv_s1),
		.geom   (geom_q),
		.in_ell (inside_s4)
	);

	always_ff @(posedge clk) begin
		ins_s[5] <= inside_s4;
		for (int k = 6; k < LATENCY; k++)
			ins_s[k] <= ins_s[k-1];
	end

	// stages 2..16: unscaled chroma
	logic [14:0] uq_s16;
	logic [14:0] vq_s16;
	logic        uneg_s16;
	logic        vneg_s16;

	ycw_chroma_div u_div_u (
		.clk      (clk),
		.mag      (umag_s1),
		.den_m1   (wm1),
		.neg      (uneg_s1),
		.quot     (uq_s16),
		.quot_neg (uneg_s16)
	);

	ycw_chroma_div u_div_v (
		.clk      (clk),
		.mag      (vmag_s1),
		.den_m1   (hm1),
		.neg      (vneg_s1),
		.quot     (vq_s16),
		.quot_neg (vneg_s16)
	);

	// stage 17: scale product
	logic [30:0] uprod_s17;
	logic [30:0] vprod_s17;
	logic        uneg_s17;
	logic        vneg_s17;

	always_ff @(posedge clk) begin
		uprod_s17 <= uq_s16 * scale_q;
		vprod_s17 <= vq_s16 * scale_q;
		uneg_s17  <= uneg_s16;
		vneg_s17  <= vneg_s16;
	end

	// stage 18: round scaled chroma to q.14
	logic [30:0] uprod_rnd;
	logic [30:0] vprod_rnd;
	logic [17:0] cu_s18;
	logic [17:0] cv_s18;
	logic        uneg_s18;
	logic        vneg_s18;

	assign uprod_rnd = uprod_s17 + 31'd2048;
	assign vprod_rnd = vprod_s17 + 31'd2048;

	always_ff @(posedge clk) begin
		cu_s18   <= uprod_rnd[29:12];
		cv_s18   <= vprod_rnd[29:12];
		uneg_s18 <= uneg_s17;
		vneg_s18 <= vneg_s17;
	end

	// stage 19: coefficient products on magnitudes
	logic [35:0] prv_s19;
	logic [35:0] pgu_s19;
	logic [35:0] pgv_s19;
	logic [35:0] pbu_s19;
	logic        uneg_s19;
	logic        vneg_s19;

	always_ff @(posedge clk) begin
		prv_s19  <= cv_s18 * COEF_RV;
		pgu_s19  <= cu_s18 * COEF_GU;
		pgv_s19  <= cv_s18 * COEF_GV;
		pbu_s19  <= cu_s18 * COEF_BU;
		uneg_s19 <= uneg_s18;
		vneg_s19 <= vneg_s18;
	end

	// stage 20: channel sums in q.22
	logic signed [38:0] y22;
	logic signed [38:0] trv;
	logic signed [38:0] tgu;
	logic signed [38:0] tgv;
	logic signed [38:0] tbu;
	logic signed [38:0] sum_s20 [3];

	assign y22 = $signed({9'd0, luma_q, 22'd0});
	assign trv = vneg_s19 ? -$signed({3'b000, prv_s19}) : $signed({3'b000, prv_s19});
	assign tgu = uneg_s19 ? -$signed({3'b000, pgu_s19}) : $signed({3'b000, pgu_s19});
	assign tgv = vneg_s19 ? -$signed({3'b000, pgv_s19}) : $signed({3'b000, pgv_s19});
	assign tbu = uneg_s19 ? -$signed({3'b000, pbu_s19}) : $signed({3'b000, pbu_s19});

	always_ff @(posedge clk) begin
		sum_s20[0] <= y22 + trv;
		sum_s20[1] <= y22 - tgu - tgv;
		sum_s20[2] <= y22 + tbu;
	end

	// stage 21: sign and magnitude
	logic [37:0] mag_s21 [3];
	logic        neg_s21 [3];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			mag_s21[c] <= sum_s20[c][38] ? 38'(-sum_s20[c]) : sum_s20[c][37:0];
			neg_s21[c] <= sum_s20[c][38];
		end
	end

	// stage 22: round to q.8, ties away from zero
	logic [37:0]     mag_rnd [3];
	logic [CM_W-1:0] cm_s22  [3];
	logic            neg_s22 [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			mag_rnd[c] = mag_s21[c] + 38'd8192;
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			cm_s22[c]  <= mag_rnd[c][CM_W+13:14];
			neg_s22[c] <= neg_s21[c];
		end
	end

	// stage 23: plain bytes, normalisation numerators and largest magnitude
	logic [7:0]       plain   [3];
	logic [2:0]       pos;
	logic [NUM_W-1:0] num     [3];
	logic [CM_W-1:0]  m_rg;
	logic [CM_W-1:0]  m_all;
	chan_t            chan_s23;
	logic [NUM_W-1:0] num_s23 [3];
	logic [CM_W-1:0]  m_s23;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (neg_s22[c])
				plain[c] = 8'd0;
			else if (cm_s22[c][CM_W-1:16] != '0)
				plain[c] = 8'hFF;
			else
				plain[c] = cm_s22[c][15:8];
			pos[c] = !neg_s22[c] && (cm_s22[c] != '0);
			num[c] = pos[c] ? ({cm_s22[c], 8'd0} - {8'd0, cm_s22[c]}) : '0;
		end
		m_rg  = (cm_s22[0] > cm_s22[1]) ? cm_s22[0] : cm_s22[1];
		m_all = (cm_s22[2] > m_rg) ? cm_s22[2] : m_rg;
	end

	always_ff @(posedge clk) begin
		chan_s23.plain_r <= plain[0];
		chan_s23.plain_g <= plain[1];
		chan_s23.plain_b <= plain[2];
		chan_s23.pos     <= pos;
		for (int c = 0; c < 3; c++)
			num_s23[c] <= num[c];
		m_s23 <= m_all;
	end

	// stages 24..31: normalisation
	logic [7:0] nq_s31 [3];
	chan_t      chan_s [24:LATENCY-1];

	for (genvar c = 0; c < 3; c++) begin : g_norm
		ycw_norm_div u_ndiv (
			.clk  (clk),
			.num  (num_s23[c]),
			.den  (m_s23),
			.quot (nq_s31[c])
		);
	end

	always_ff @(posedge clk) begin
		chan_s[24] <= chan_s23;
		for (int k = 25; k < LATENCY; k++)
			chan_s[k] <= chan_s[k-1];
	end

	// stage 32: output beat
	logic       drawn;
	logic [7:0] pix [3];
	chan_t      ch_l;

	always_comb begin
		ch_l  = chan_s[LATENCY-1];
		drawn = !mask_q || ins_s[LATENCY-1];
		if (norm_q) begin
			pix[0] = ch_l.pos[0] ? nq_s31[0] : 8'd0;
			pix[1] = ch_l.pos[1] ? nq_s31[1] : 8'd0;
			pix[2] = ch_l.pos[2] ? nq_s31[2] : 8'd0;
		end else begin
			pix[0] = ch_l.plain_r;
			pix[1] = ch_l.plain_g;
			pix[2] = ch_l.plain_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= side_s[LATENCY-1].valid;
	end

	always_ff @(posedge clk) begin
		red        <= drawn ? pix[0] : 8'd0;
		green      <= drawn ? pix[1] : 8'd0;
		blue       <= drawn ? pix[2] : 8'd0;
		alpha      <= drawn ? 8'hFF : 8'd0;
		inside_res <= drawn;
		out_row    <= side_s[LATENCY-1].row;
	end

endmodule

// File: rtl/ycw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycw_checker
// Port-level checks of the colour wheel pixel generator, bound to the top.
// ----------------------------------------------------------------------------
module ycw_checker import ycw_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [COORD_W-1:0]   column,
	input logic [COORD_W-1:0]   row_index,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data,
	input logic                 done,
	input logic [7:0]           red,
	input logic [7:0]           green,
	input logic [7:0]           blue,
	input logic [7:0]           alpha,
	input logic                 inside_res,
	input logic [COORD_W-1:0]   out_row
);

	// every accepted beat comes out after the fixed latency
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted beat did not produce a result");

	// no result without a beat behind it
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result without an accepted beat");

	a_masked: assert property (@(posedge clk) disable iff (!arst_n)
		done && !inside_res |-> red == 8'd0 && green == 8'd0 && blue == 8'd0
			&& alpha == 8'd0)
		else $error("masked pixel is not transparent black");

	a_drawn: assert property (@(posedge clk) disable iff (!arst_n)
		done && inside_res |-> alpha == 8'hFF)
		else $error("drawn pixel is not opaque");

	// geometry settles before the next beat
	a_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("start not held off after a register write");

endmodule

bind yuv_color_wheel_pixel_top ycw_checker u_ycw_checker (.*);
